### rtl/pip_pkg.sv
`default_nettype none

package pip_pkg;

    // Sizing
    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 24;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SUM_W        = PROD_W + 1;

    // Transaction kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Location codes
    typedef logic [1:0] t_loc;
    localparam t_loc LOC_OUTSIDE = 2'd0;
    localparam t_loc LOC_BORDER  = 2'd1;
    localparam t_loc LOC_INSIDE  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME,
        S_FIRST,
        S_EDGE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_EVAL,
        S_DONE
    } t_state;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MSEL_AX_BY,
        MSEL_AY_BX,
        MSEL_AX_BX,
        MSEL_AY_BY
    } t_msel;

    // Vertex store write port
    typedef struct packed {
        logic                          en;
        logic [IDX_W-1:0]              addr;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } t_vst_wr;

endpackage

`default_nettype wire

### rtl/pip_in_if.sv
`default_nettype none

interface pip_in_if;
    import pip_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic                          last_vertex;

    modport source (
        output valid, kind, coord_x, coord_y, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, kind, coord_x, coord_y, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

### rtl/pip_out_if.sv
`default_nettype none

interface pip_out_if;
    import pip_pkg::*;

    logic  valid;
    logic  ready;
    t_loc  location;

    modport source (
        output valid, location,
        input  ready
    );

    modport sink (
        input  valid, location,
        output ready
    );
endinterface

`default_nettype wire

### rtl/pip_vstore.sv
`default_nettype none

// Vertex store: one write port, one registered read port, x and y side by side
module pip_vstore (
    input  wire logic                                   i_clk,
    input  wire pip_pkg::t_vst_wr                       i_wr,
    input  wire logic [pip_pkg::IDX_W-1:0]              i_rd_addr,
    output logic signed [pip_pkg::COORD_BITS-1:0]       o_rd_x,
    output logic signed [pip_pkg::COORD_BITS-1:0]       o_rd_y
);
    import pip_pkg::*;

    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_x[i_wr.addr] <= i_wr.x;
            mem_y[i_wr.addr] <= i_wr.y;
        end
        o_rd_x <= mem_x[i_rd_addr];
        o_rd_y <= mem_y[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/point_in_polygon.sv
`default_nettype none

// Channel   Dir  Payload                                   Transaction
// i_pt      in   kind, coord_x, coord_y, last_vertex       valid & ready
// o_res     out  location                                  valid & ready
//
// A query holds the block while it walks the stored edges (an empty polygon goes
// straight to the result), and a border edge ends the walk early: each edge
// goes through one shared 25x25 multiplier four times.
// Reset (synchronous, active low) empties the polygon; the store is not cleared.
// The result sits in an output register, so vertex loads are taken while a
// result waits; a finished query waits there until the register is free.
module point_in_polygon (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pip_in_if.sink     i_pt,
    pip_out_if.source  o_res
);
    import pip_pkg::*;

    function automatic logic signed [DIFF_W-1:0] f_diff(
        input logic signed [COORD_BITS-1:0] v,
        input logic signed [COORD_BITS-1:0] p
    );
        return DIFF_W'(v) - DIFF_W'(p);
    endfunction

    t_state r_state, n_state;

    logic [CNT_W-1:0]              r_count;
    logic                          r_closed;
    logic [CNT_W-1:0]              r_idx;
    logic signed [COORD_BITS-1:0]  r_px, r_py;
    logic signed [DIFF_W-1:0]      r_ax, r_ay, r_bx, r_by, r_fx, r_fy;
    logic signed [PROD_W-1:0]      r_prod, r_l, r_r, r_d;
    logic                          r_parity;
    logic                          r_last;
    t_loc                          r_loc;
    logic                          r_out_valid;
    t_loc                          r_res;

    logic                          in_acc;
    logic                          out_free;
    logic [CNT_W-1:0]              eff_count;
    t_vst_wr                       vst_wr;
    logic signed [COORD_BITS-1:0]  rd_x, rd_y;
    t_msel                         msel;
    logic signed [DIFF_W-1:0]      op_a, op_b;
    logic signed [SUM_W-1:0]       dot;
    logic                          swap;
    logic signed [DIFF_W-1:0]      lo_y, hi_y;
    logic                          cross_neg;
    logic                          is_border;
    logic                          toggle;
    logic                          closing;

    // Handshake helpers
    assign in_acc   = i_pt.valid & i_pt.ready;
    assign out_free = ~r_out_valid | o_res.ready;

    // Vertex write path: a load on a closed polygon restarts the count
    assign eff_count   = r_closed ? '0 : r_count;
    assign vst_wr.en   = in_acc && (i_pt.kind == KIND_VERTEX)
                         && (eff_count < CNT_W'(MAX_VERTICES));
    assign vst_wr.addr = eff_count[IDX_W-1:0];
    assign vst_wr.x    = i_pt.coord_x;
    assign vst_wr.y    = i_pt.coord_y;

    pip_vstore u_vstore (
        .i_clk     (i_clk),
        .i_wr      (vst_wr),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    // Shared multiplier operand mux
    always_comb begin
        case (msel)
            MSEL_AX_BY: begin op_a = r_ax; op_b = r_by; end
            MSEL_AY_BX: begin op_a = r_ay; op_b = r_bx; end
            MSEL_AX_BX: begin op_a = r_ax; op_b = r_bx; end
            MSEL_AY_BY: begin op_a = r_ay; op_b = r_by; end
            default:    begin op_a = r_ax; op_b = r_by; end
        endcase
    end

    // Edge evaluation: ax*bx + ay*by arrives as r_d + r_prod
    assign dot       = SUM_W'(r_d) + SUM_W'(r_prod);
    assign is_border = (r_l == r_r) && (dot <= 0);
    assign swap      = r_ay > r_by;
    assign lo_y      = swap ? r_by : r_ay;
    assign hi_y      = swap ? r_ay : r_by;
    assign cross_neg = swap ? (r_r < r_l) : (r_l < r_r);
    assign toggle    = (lo_y <= 0) && (hi_y > 0) && cross_neg;
    assign closing   = (r_idx == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_pt.kind == KIND_QUERY)) begin
                    n_state = (r_count == '0) ? S_DONE : S_PRIME;
                end
            end
            S_PRIME: n_state = S_FIRST;
            S_FIRST: n_state = S_EDGE;
            S_EDGE:  n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_EVAL;
            S_EVAL: begin
                n_state = (is_border || r_last) ? S_DONE : S_EDGE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_pt.ready = 1'b0;
        msel       = MSEL_AX_BY;
        case (r_state)
            S_IDLE:  i_pt.ready = 1'b1;
            S_M0:    msel = MSEL_AX_BY;
            S_M1:    msel = MSEL_AY_BX;
            S_M2:    msel = MSEL_AX_BX;
            S_M3:    msel = MSEL_AY_BY;
            default: msel = MSEL_AX_BY;
        endcase
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.location = r_res;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_closed    <= 1'b1;
            r_idx       <= '0;
            r_parity    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // polygon bookkeeping on a vertex load
            if (in_acc && (i_pt.kind == KIND_VERTEX)) begin
                r_count  <= vst_wr.en ? eff_count + CNT_W'(1) : eff_count;
                r_closed <= i_pt.last_vertex;
            end

            // edge walk
            case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_parity <= 1'b0;
                    r_last   <= 1'b0;
                end
                S_PRIME: r_idx <= CNT_W'(1);
                S_EDGE: begin
                    r_last <= closing;
                    if (!closing) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_EVAL: r_parity <= r_parity ^ toggle;
                default: ;
            endcase

            // output register
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        case (r_state)
            S_IDLE: begin
                r_px  <= i_pt.coord_x;
                r_py  <= i_pt.coord_y;
                r_loc <= LOC_OUTSIDE;
            end
            S_FIRST: begin
                r_bx <= f_diff(rd_x, r_px);
                r_by <= f_diff(rd_y, r_py);
                r_fx <= f_diff(rd_x, r_px);
                r_fy <= f_diff(rd_y, r_py);
            end
            S_EDGE: begin
                r_ax <= r_bx;
                r_ay <= r_by;
                r_bx <= closing ? r_fx : f_diff(rd_x, r_px);
                r_by <= closing ? r_fy : f_diff(rd_y, r_py);
            end
            S_M1: r_l <= r_prod;
            S_M2: r_r <= r_prod;
            S_M3: r_d <= r_prod;
            S_EVAL: begin
                if (is_border) begin
                    r_loc <= LOC_BORDER;
                end else if (r_parity ^ toggle) begin
                    r_loc <= LOC_INSIDE;
                end else begin
                    r_loc <= LOC_OUTSIDE;
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_res <= r_loc;
        end
    end

endmodule

`default_nettype wire
